### sv/clc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Card number Luhn classifier package
// Types, constants and small arithmetic helpers shared by the classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

	typedef logic [3:0] digit_t;
	typedef logic [4:0] count_t;
	typedef logic [7:0] prefix_t;

	typedef enum logic [1:0] {
		BRAND_INVALID = 2'd0,
		BRAND_AMEX    = 2'd1,
		BRAND_MASTER  = 2'd2,
		BRAND_VISA    = 2'd3
	} brand_t;

	// One digit item as held in the input stage.
	typedef struct packed {
		digit_t digit;
		logic   last;
	} digit_item_t;

	// The result of one card number.
	typedef struct packed {
		logic   checksum_ok;
		brand_t brand;
	} verdict_t;

	localparam count_t  COUNT_MAX      = 5'd31;
	localparam count_t  AMEX_LEN       = 5'd15;
	localparam count_t  MASTER_LEN     = 5'd16;
	localparam count_t  VISA_LONG_LEN  = 5'd16;
	localparam count_t  VISA_SHORT_LEN = 5'd13;
	localparam prefix_t AMEX_PRE_A     = 8'd34;
	localparam prefix_t AMEX_PRE_B     = 8'd37;
	localparam prefix_t MASTER_PRE_LO  = 8'd51;
	localparam prefix_t MASTER_PRE_HI  = 8'd55;
	localparam digit_t  VISA_LEAD      = 4'd4;
	localparam digit_t  DIGIT_BASE     = 4'd10;

	// Undoubled share of a digit: the value mod 10 (codes above nine wrap).
	function automatic digit_t digit_mod10(input digit_t v);
		digit_t r;
		r = (v >= DIGIT_BASE) ? digit_t'(v - DIGIT_BASE) : v;
		return r;
	endfunction

	// Doubled share: 2v, less nine when that reaches ten, then taken mod 10.
	function automatic digit_t doubled_share(input digit_t v);
		logic [4:0] p;
		p = {v, 1'b0};
		if (p >= 5'd10) begin
			p = p - 5'd9;
		end
		if (p >= 5'd20) begin
			p = p - 5'd20;
		end else if (p >= 5'd10) begin
			p = p - 5'd10;
		end
		return p[3:0];
	endfunction

	// Sum of two values below ten, reduced mod 10.
	function automatic digit_t add_mod10(input digit_t a, input digit_t b);
		logic [4:0] s;
		s = 5'(a) + 5'(b);
		if (s >= 5'd10) begin
			s = s - 5'd10;
		end
		return s[3:0];
	endfunction

	// Brand from the digit count and the first two digits.
	function automatic brand_t classify(input count_t n, input digit_t d0, input digit_t d1);
		prefix_t pre;
		brand_t  b;
		pre = prefix_t'({d0, 3'b000}) + prefix_t'({d0, 1'b0}) + prefix_t'(d1);
		if (n == AMEX_LEN && (pre == AMEX_PRE_A || pre == AMEX_PRE_B)) begin
			b = BRAND_AMEX;
		end else if (n == MASTER_LEN && pre >= MASTER_PRE_LO && pre <= MASTER_PRE_HI
				&& d0 < DIGIT_BASE && d1 < DIGIT_BASE) begin
			b = BRAND_MASTER;
		end else if ((n == VISA_LONG_LEN || n == VISA_SHORT_LEN) && d0 == VISA_LEAD) begin
			b = BRAND_VISA;
		end else begin
			b = BRAND_INVALID;
		end
		return b;
	endfunction

endpackage
`default_nettype wire

### sv/clc_digit_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Digit channel
// Valid/ready channel that carries one card number digit per item.
// ----------------------------------------------------------------------------
interface clc_digit_if;
	logic            valid;
	logic            ready;
	clc_pkg::digit_t digit;
	logic            last;

	modport source (output valid, output digit, output last, input ready);
	modport sink (input valid, input digit, input last, output ready);
endinterface
`default_nettype wire

### sv/clc_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the verdict for one card number.
// ----------------------------------------------------------------------------
interface clc_result_if;
	logic            valid;
	logic            ready;
	logic            checksum_ok;
	clc_pkg::brand_t brand;

	modport source (output valid, output checksum_ok, output brand, input ready);
	modport sink (input valid, input checksum_ok, input brand, output ready);
endinterface
`default_nettype wire

### sv/clc_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn accumulator
// Holds both parity sums, the digit count and the first two digits, and
// forms the verdict for the digit being stepped in.
// ----------------------------------------------------------------------------
module clc_accum (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire clc_pkg::digit_item_t item,
	output clc_pkg::verdict_t         verdict
);
	import clc_pkg::*;

	digit_t sum_undbl_q;
	digit_t sum_dbl_q;
	count_t count_q;
	digit_t lead_q;
	digit_t second_q;

	digit_t sum_undbl_nx;
	digit_t sum_dbl_nx;
	count_t count_nx;
	digit_t lead_nx;
	digit_t second_nx;

	// The sums swap roles on every digit: the newest digit is undoubled in one
	// and doubled in the other.
	always_comb begin
		sum_undbl_nx = add_mod10(sum_dbl_q, digit_mod10(item.digit));
		sum_dbl_nx   = add_mod10(sum_undbl_q, doubled_share(item.digit));
		count_nx     = (count_q < COUNT_MAX) ? count_t'(count_q + 5'd1) : count_q;
		lead_nx      = (count_q == 5'd0) ? item.digit : lead_q;
		second_nx    = (count_q == 5'd1) ? item.digit : second_q;
	end

	// Verdict as it stands if this digit is the last one.
	always_comb begin
		verdict.checksum_ok = (sum_undbl_nx == 4'd0);
		verdict.brand       = verdict.checksum_ok ? classify(count_nx, lead_nx, second_nx)
		                                          : BRAND_INVALID;
	end

	// State registers; the final digit of a number returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_undbl_q <= '0;
			sum_dbl_q   <= '0;
			count_q     <= '0;
			lead_q      <= '0;
			second_q    <= '0;
		end else if (step) begin
			if (item.last) begin
				sum_undbl_q <= '0;
				sum_dbl_q   <= '0;
				count_q     <= '0;
				lead_q      <= '0;
				second_q    <= '0;
			end else begin
				sum_undbl_q <= sum_undbl_nx;
				sum_dbl_q   <= sum_dbl_nx;
				count_q     <= count_nx;
				lead_q      <= lead_nx;
				second_q    <= second_nx;
			end
		end
	end

endmodule
`default_nettype wire

### sv/clc_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one verdict until the sink takes it.
// ----------------------------------------------------------------------------
module clc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire clc_pkg::verdict_t value,
	output logic                   can_load,
	clc_result_if.source           result
);
	import clc_pkg::*;

	logic     valid_q;
	verdict_t value_q;

	// A new verdict may enter when the register is empty or being drained.
	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value;
		end
	end

	assign result.valid       = valid_q;
	assign result.checksum_ok = value_q.checksum_ok;
	assign result.brand       = value_q.brand;

endmodule
`default_nettype wire

### sv/card_number_luhn_classifier.sv
// The last digit is held in the input register, and its verdict is then
// registered in the result register. Throughput: one digit per cycle, save for
// stalls; the accumulator update is a single mod-10 add per parity sum between
// the input and state registers. A digit stalls only while a finished verdict
// waits and the sink is not ready. Reset (arst_n low, asynchronous) clears the
// sums, the count, the stored prefix digits and both valid flags.
`default_nettype none
// ----------------------------------------------------------------------------
// Card number Luhn classifier
// Takes card number digits one per item and gives the Luhn verdict and the
// card brand once the last digit has been taken.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier (
	input  wire logic    clk,
	input  wire logic    arst_n,
	clc_digit_if.sink    card_digit,
	clc_result_if.source verdict
);
	import clc_pkg::*;

	logic        valid_s1;
	digit_item_t item_s1;
	logic        advance_s1;
	logic        can_load;
	verdict_t    verdict_nx;

	// A digit that is not last never needs the result register.
	assign advance_s1       = valid_s1 && (!item_s1.last || can_load);
	assign card_digit.ready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (card_digit.ready) begin
			valid_s1 <= card_digit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (card_digit.ready && card_digit.valid) begin
			item_s1 <= '{digit: card_digit.digit, last: card_digit.last};
		end
	end

	clc_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.item    (item_s1),
		.verdict (verdict_nx)
	);

	clc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance_s1 && item_s1.last),
		.value    (verdict_nx),
		.can_load (can_load),
		.result   (verdict)
	);

endmodule
`default_nettype wire

### sv/clc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Classifier port checker
// Watches the ports of the classifier and flags behavior it must never show.
// ----------------------------------------------------------------------------
module clc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            in_last,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic            out_ok,
	input wire clc_pkg::brand_t out_brand
);
	import clc_pkg::*;

	// A brand is only given to a number whose checksum passed.
	a_brand_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_brand != BRAND_INVALID |-> out_ok)
		else $error("brand given with a failed checksum");

	// A fresh verdict follows the acceptance of a last digit.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without a preceding last digit");

	// A waiting verdict stays offered.
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict withdrawn before it was taken");

	// A waiting verdict keeps its value.
	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_ok) && $stable(out_brand))
		else $error("verdict changed while stalled");

endmodule

bind card_number_luhn_classifier clc_checker u_clc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (card_digit.valid),
	.in_ready  (card_digit.ready),
	.in_last   (card_digit.last),
	.out_valid (verdict.valid),
	.out_ready (verdict.ready),
	.out_ok    (verdict.checksum_ok),
	.out_brand (verdict.brand)
);
`default_nettype wire
